>>> hdl/oml_pkg.sv
`default_nettype none

package oml_pkg;

  localparam int unsigned NumMods  = 4;
  localparam int unsigned KeyW     = 16;
  localparam int unsigned CfgIdxW  = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegShiftTrig  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCtrlTrig   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAltTrig    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGuiTrig    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLayerTrig  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCancelA    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCancelB    = 3'd6;

  typedef enum logic [2:0] {
    M_UP_UNQ     = 3'd0,
    M_DN_UNUSED  = 3'd1,
    M_DN_USED    = 3'd2,
    M_UP_Q       = 3'd3,
    M_UP_Q_LAYER = 3'd4
  } mod_mode_t;

  typedef enum logic [2:0] {
    L_UP_UNQ    = 3'd0,
    L_UP_Q      = 3'd1,
    L_UP_PEND   = 3'd2,
    L_DN_UNUSED = 3'd3,
    L_DN_PEND   = 3'd4,
    L_DN_USED   = 3'd5
  } layer_mode_t;

  // decoded key event
  typedef struct packed {
    logic               press;
    logic [NumMods-1:0] trig_hit;
    logic               layer_hit;
    logic               cancel_hit;
  } key_event_t;

  // layer machine to modifier machines
  typedef struct packed {
    logic busy;         // layer in a state that parks a queued modifier
    logic clr_q_layer;  // layer trigger released after use
  } layer_ctl_t;

endpackage

`default_nettype wire

>>> hdl/oneshot_modifier_layer_fsm_unit.sv
`default_nettype none

// Channel  Direction  Signals
// in       input      in_valid, in_ready, in_key_code[15:0], in_key_pressed
// out      output     out_valid, out_ready, out_mods_held[3:0], out_layer_active
// cfg      input      cfg_we, cfg_idx[2:0], cfg_wdata[15:0]
//
// One item per cycle unless out_ready stalls; an accepted item passes the input
// register, then the result register fed by the machine update, before out_valid rises.
// The modifier and layer state registers advance when the item in the input
// register moves into the result register. A stall on out_ready holds both
// stages; in_ready stays high while the input register is empty or moving.
// Synchronous reset clears all machines and the trigger/cancel keycodes.

module oneshot_modifier_layer_fsm_unit
  import oml_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [KeyW-1:0]    in_key_code,
  input  wire logic               in_key_pressed,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [NumMods-1:0]      out_mods_held,
  output logic                    out_layer_active,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_idx,
  input  wire logic [KeyW-1:0]    cfg_wdata
);

  logic [KeyW-1:0]    trig_r [NumMods];
  logic [KeyW-1:0]    layer_trig_r, cancel_a_r, cancel_b_r;
  logic               in_vld_r;
  logic [KeyW-1:0]    kc_r;
  logic               press_r;
  logic               out_vld_r;
  logic [NumMods-1:0] mods_r, held_nxt;
  logic               layer_r, flag_nxt;
  logic               adv, step;
  key_event_t         ev;
  layer_ctl_t         lctl;

  assign adv      = !out_vld_r || out_ready;
  assign step     = in_vld_r && adv;
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumMods; i++) begin
        trig_r[i] <= '0;
      end
      layer_trig_r <= '0;
      cancel_a_r   <= '0;
      cancel_b_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegShiftTrig: trig_r[0]    <= cfg_wdata;
        RegCtrlTrig:  trig_r[1]    <= cfg_wdata;
        RegAltTrig:   trig_r[2]    <= cfg_wdata;
        RegGuiTrig:   trig_r[3]    <= cfg_wdata;
        RegLayerTrig: layer_trig_r <= cfg_wdata;
        RegCancelA:   cancel_a_r   <= cfg_wdata;
        RegCancelB:   cancel_b_r   <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kc_r    <= in_key_code;
      press_r <= in_key_pressed;
    end
  end

  oml_key_match u_match (
    .key_code    (kc_r),
    .key_pressed (press_r),
    .trig        (trig_r),
    .layer_trig  (layer_trig_r),
    .cancel_a    (cancel_a_r),
    .cancel_b    (cancel_b_r),
    .ev          (ev)
  );

  for (genvar g = 0; g < NumMods; g++) begin : g_mod
    oml_mod_fsm u_mod (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (step),
      .own_hit  (ev.trig_hit[g]),
      .ev       (ev),
      .lctl     (lctl),
      .held_nxt (held_nxt[g])
    );
  end

  oml_layer_fsm u_layer (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .ev       (ev),
    .lctl     (lctl),
    .flag_nxt (flag_nxt)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      mods_r  <= held_nxt;
      layer_r <= flag_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_mods_held    = mods_r;
  assign out_layer_active = layer_r;

endmodule

`default_nettype wire

>>> hdl/oml_key_match.sv
`default_nettype none

module oml_key_match
  import oml_pkg::*;
(
  input  wire logic [KeyW-1:0] key_code,
  input  wire logic            key_pressed,
  input  wire logic [KeyW-1:0] trig [NumMods],
  input  wire logic [KeyW-1:0] layer_trig,
  input  wire logic [KeyW-1:0] cancel_a,
  input  wire logic [KeyW-1:0] cancel_b,
  output key_event_t           ev
);

  always_comb begin
    ev.press = key_pressed;
    for (int i = 0; i < NumMods; i++) begin
      ev.trig_hit[i] = (trig[i] == key_code);
    end
    ev.layer_hit  = (layer_trig == key_code);
    ev.cancel_hit = (cancel_a == key_code) || (cancel_b == key_code);
  end

endmodule

`default_nettype wire

>>> hdl/oml_mod_fsm.sv
`default_nettype none

module oml_mod_fsm
  import oml_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic       own_hit,
  input  wire key_event_t ev,
  input  wire layer_ctl_t lctl,
  output logic            held_nxt
);

  mod_mode_t mode_r, mode_nxt, mode_stp;
  logic      ignored;

  always_comb begin
    ignored  = (|ev.trig_hit) || ev.layer_hit;
    mode_stp = mode_r;
    if (own_hit) begin
      if (ev.press) begin
        mode_stp = M_DN_UNUSED;
      end else if (mode_r == M_DN_UNUSED) begin
        mode_stp = M_UP_Q;
      end else if (mode_r == M_DN_USED) begin
        mode_stp = M_UP_UNQ;
      end
    end else if (ev.press) begin
      if (ev.cancel_hit) begin
        mode_stp = M_UP_UNQ;
      end
    end else if (!ignored) begin
      case (mode_r)
        M_DN_UNUSED: mode_stp = M_DN_USED;
        M_UP_Q:      mode_stp = lctl.busy ? M_UP_Q_LAYER : M_UP_UNQ;
        default:     mode_stp = mode_r;
      endcase
    end
    // layer machine drops modifiers parked on it
    mode_nxt = mode_stp;
    if (lctl.clr_q_layer && mode_stp == M_UP_Q_LAYER) begin
      mode_nxt = M_UP_UNQ;
    end
    held_nxt = (mode_nxt != M_UP_UNQ);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_UP_UNQ;
    end else if (step) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/oml_layer_fsm.sv
`default_nettype none

module oml_layer_fsm
  import oml_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire key_event_t ev,
  output layer_ctl_t      lctl,
  output logic            flag_nxt
);

  layer_mode_t        mode_r, mode_nxt;
  logic               flag_r;
  logic [NumMods-1:0] keys_r, keys_nxt;

  always_comb begin
    mode_nxt = mode_r;
    flag_nxt = flag_r;
    keys_nxt = keys_r;
    lctl.clr_q_layer = 1'b0;
    lctl.busy = mode_r inside {L_UP_PEND, L_DN_UNUSED, L_DN_PEND, L_DN_USED};
    if (ev.layer_hit) begin
      if (ev.press) begin
        if (mode_r == L_UP_UNQ) begin
          flag_nxt = 1'b1;
        end
        mode_nxt = L_DN_UNUSED;
      end else begin
        case (mode_r)
          L_DN_UNUSED: mode_nxt = L_UP_Q;
          L_DN_USED: begin
            mode_nxt = L_UP_UNQ;
            flag_nxt = 1'b0;
            lctl.clr_q_layer = 1'b1;
          end
          L_DN_PEND: mode_nxt = L_UP_PEND;
          default:   mode_nxt = mode_r;
        endcase
      end
    end else if (ev.press) begin
      keys_nxt = keys_r | ev.trig_hit;
    end else begin
      keys_nxt = keys_r & ~ev.trig_hit;
      if (|ev.trig_hit) begin
        case (mode_r)
          L_DN_PEND, L_DN_UNUSED: begin
            if (|keys_nxt) begin
              mode_nxt = L_DN_PEND;
            end else begin
              mode_nxt = L_DN_USED;
              flag_nxt = 1'b0;
            end
          end
          L_UP_Q, L_UP_PEND: begin
            if (|keys_nxt) begin
              mode_nxt = L_UP_PEND;
            end else begin
              mode_nxt = L_UP_UNQ;
              flag_nxt = 1'b0;
            end
          end
          default: mode_nxt = mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= L_UP_UNQ;
      flag_r <= 1'b0;
      keys_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      flag_r <= flag_nxt;
      keys_r <= keys_nxt;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none

module testbench;
  import oml_pkg::*;

  localparam int NumKeyRegs    = int'(RegCancelB) + 1;
  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic [KeyW-1:0] code;
    logic            press;
  } key_item_t;

  typedef struct packed {
    logic [NumMods-1:0] mods;
    logic               layer;
  } osm_view_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [KeyW-1:0]     in_key_code    = '0;
  logic                in_key_pressed = 1'b0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [NumMods-1:0]  out_mods_held;
  logic                out_layer_active;
  logic                cfg_we         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx        = '0;
  logic [KeyW-1:0]     cfg_wdata      = '0;

  // shadow of the trigger/cancel keycodes and of the one-shot machines
  logic [KeyW-1:0]     key_reg   [NumKeyRegs];
  logic [KeyW-1:0]     next_keys [NumKeyRegs];
  mod_mode_t           osm_mode  [NumMods];
  layer_mode_t         osl_mode;
  logic                osl_on;
  logic [NumMods-1:0]  trig_down;

  key_item_t           send_items[$];
  osm_view_t           expected_views[$];

  int                  in_gap    = 0;
  int                  out_stall = 0;
  bit                  steady    = 1'b0;
  bit                  in_taken  = 1'b0;
  int                  quiet     = 0;
  int                  n_errors  = 0;
  int                  n_events  = 0;
  int                  n_results = 0;
  int                  n_settings = 0;

  oneshot_modifier_layer_fsm_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_key_code      (in_key_code),
    .in_key_pressed   (in_key_pressed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mods_held    (out_mods_held),
    .out_layer_active (out_layer_active),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic osm_view_t predict_event(input logic [KeyW-1:0] kc, input logic press);
    layer_mode_t        lmode_prev;
    logic [NumMods-1:0] hits;
    logic               is_layer;
    logic               is_cancel;
    logic               layer_busy;
    osm_view_t          view;
    int                 i;
    lmode_prev = osl_mode;
    for (i = 0; i < NumMods; i++) hits[i] = (kc == key_reg[int'(RegShiftTrig) + i]);
    is_layer   = (kc == key_reg[RegLayerTrig]);
    is_cancel  = (kc == key_reg[RegCancelA]) || (kc == key_reg[RegCancelB]);
    layer_busy = (lmode_prev == L_UP_PEND) || (lmode_prev == L_DN_UNUSED) ||
                 (lmode_prev == L_DN_PEND) || (lmode_prev == L_DN_USED);

    // modifiers first, all against the layer mode from before this item
    for (i = 0; i < NumMods; i++) begin
      if (hits[i]) begin
        if (press) osm_mode[i] = M_DN_UNUSED;
        else if (osm_mode[i] == M_DN_UNUSED) osm_mode[i] = M_UP_Q;
        else if (osm_mode[i] == M_DN_USED) osm_mode[i] = M_UP_UNQ;
      end else if (press) begin
        if (is_cancel && osm_mode[i] != M_UP_UNQ) osm_mode[i] = M_UP_UNQ;
      end else if (hits == '0 && !is_layer) begin
        if (osm_mode[i] == M_DN_UNUSED) osm_mode[i] = M_DN_USED;
        else if (osm_mode[i] == M_UP_Q) osm_mode[i] = layer_busy ? M_UP_Q_LAYER : M_UP_UNQ;
      end
    end

    if (is_layer) begin
      if (press) begin
        if (osl_mode == L_UP_UNQ) osl_on = 1'b1;
        osl_mode = L_DN_UNUSED;
      end else begin
        case (osl_mode)
          L_DN_UNUSED: osl_mode = L_UP_Q;
          L_DN_PEND:   osl_mode = L_UP_PEND;
          L_DN_USED: begin
            osl_mode = L_UP_UNQ;
            osl_on   = 1'b0;
            for (i = 0; i < NumMods; i++)
              if (osm_mode[i] == M_UP_Q_LAYER) osm_mode[i] = M_UP_UNQ;
          end
          default: ;
        endcase
      end
    end else if (press) begin
      trig_down = trig_down | hits;
    end else begin
      trig_down = trig_down & ~hits;
      if (hits != '0) begin
        if (osl_mode == L_DN_PEND || osl_mode == L_DN_UNUSED) begin
          if (trig_down != '0) osl_mode = L_DN_PEND;
          else begin
            osl_mode = L_DN_USED;
            osl_on   = 1'b0;
          end
        end else if (osl_mode == L_UP_Q || osl_mode == L_UP_PEND) begin
          if (trig_down != '0) osl_mode = L_UP_PEND;
          else begin
            osl_mode = L_UP_UNQ;
            osl_on   = 1'b0;
          end
        end
      end
    end

    for (i = 0; i < NumMods; i++) view.mods[i] = (osm_mode[i] != M_UP_UNQ);
    view.layer = osl_on;
    return view;
  endfunction

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (steady || r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(4, 30));
  endfunction

  function automatic logic [KeyW-1:0] plain_key();
    return KeyW'(16'h0004 + $urandom_range(0, 3));
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 65) return key_reg[$urandom_range(0, NumKeyRegs - 1)];
    if (r < 85) return plain_key();
    return KeyW'($urandom);
  endfunction

  task automatic queue_key(input logic [KeyW-1:0] code, input logic press);
    key_item_t it;
    it.code  = code;
    it.press = press;
    send_items.push_back(it);
  endtask

  task automatic add_sequence();
    logic [KeyW-1:0] m;
    logic [KeyW-1:0] n;
    logic [KeyW-1:0] lt;
    logic [KeyW-1:0] held [3];
    int              kind;
    int              cnt;
    int              j;
    bit              early;
    kind = int'($urandom_range(0, 9));
    m    = key_reg[$urandom_range(0, NumMods - 1)];
    n    = plain_key();
    lt   = key_reg[RegLayerTrig];
    case (kind)
      0, 1: begin
        queue_key(m, 1'b1); queue_key(m, 1'b0);
        queue_key(n, 1'b1); queue_key(n, 1'b0);
      end
      2: begin
        queue_key(m, 1'b1); queue_key(n, 1'b1);
        queue_key(n, 1'b0); queue_key(m, 1'b0);
      end
      3, 4: begin
        cnt = int'($urandom_range(1, 3));
        queue_key(lt, 1'b1);
        for (j = 0; j < cnt; j++) begin
          held[j] = key_reg[$urandom_range(0, NumMods - 1)];
          queue_key(held[j], 1'b1);
        end
        if ($urandom_range(0, 1) != 0) begin
          queue_key(n, 1'b1); queue_key(n, 1'b0);
        end
        early = 1'($urandom_range(0, 1));
        if (early) queue_key(lt, 1'b0);
        for (j = 0; j < cnt; j++) queue_key(held[j], 1'b0);
        if ($urandom_range(0, 2) == 0) begin
          queue_key(n, 1'b1); queue_key(n, 1'b0);
        end
        if (!early) queue_key(lt, 1'b0);
      end
      5: begin
        queue_key(m, 1'b1); queue_key(m, 1'b0);
        queue_key(key_reg[($urandom_range(0, 1) != 0) ? RegCancelB : RegCancelA], 1'b1);
        queue_key(n, 1'b1); queue_key(n, 1'b0);
      end
      default: begin
        cnt = int'($urandom_range(1, 4));
        for (j = 0; j < cnt; j++) queue_key(rand_key(), 1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  // wait for the pipeline to empty and every expected result to be checked, then idle
  task automatic drain();
    do @(posedge clk);
    while (send_items.size() != 0 || in_valid || expected_views.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_keys();
    int r;
    for (r = 0; r < NumKeyRegs; r++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_idx   <= CfgIdxW'(r);
      cfg_wdata <= next_keys[r];
      key_reg[r] = next_keys[r];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic run_random(input int n_items, input bit no_idle);
    steady = no_idle;
    while (send_items.size() < n_items) add_sequence();
    drain();
    steady = 1'b0;
  endtask

  // driver: present the next item once the current one is taken
  always @(negedge clk) begin : drive
    key_item_t nxt;
    if (rst_n) begin
      if (in_taken || !in_valid) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap   = in_gap - 1;
        end else if (send_items.size() != 0) begin
          nxt            = send_items.pop_front();
          in_valid       <= 1'b1;
          in_key_code    <= nxt.code;
          in_key_pressed <= nxt.press;
          in_gap         = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall = out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  // monitor: predict on accept, check on result
  always @(posedge clk) begin : observe
    osm_view_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_views.push_back(predict_event(in_key_code, in_key_pressed));
        n_events++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_views.size() == 0) begin
          n_errors++;
          $display("%0t: result with nothing expected, mods_held %h layer_active %b",
                   $time, out_mods_held, out_layer_active);
        end else begin
          want = expected_views.pop_front();
          if (out_mods_held !== want.mods) begin
            n_errors++;
            $display("%0t: out_mods_held expected %h, got %h", $time, want.mods, out_mods_held);
          end
          if (out_layer_active !== want.layer) begin
            n_errors++;
            $display("%0t: out_layer_active expected %b, got %b",
                     $time, want.layer, out_layer_active);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchdogLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    int r;
    logic [KeyW-1:0] ks, kc, ka, kg, kl, kx1, kx2;
    for (r = 0; r < NumKeyRegs; r++) key_reg[r] = '0;
    for (r = 0; r < NumMods; r++) osm_mode[r] = M_UP_UNQ;
    osl_mode  = L_UP_UNQ;
    osl_on    = 1'b0;
    trig_down = '0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // keycodes still at reset: every trigger and cancel key share code zero
    run_random(80, 1'b0);

    next_keys[RegShiftTrig] = 16'h00E1;
    next_keys[RegCtrlTrig]  = 16'h00E0;
    next_keys[RegAltTrig]   = 16'h00E2;
    next_keys[RegGuiTrig]   = 16'h00E3;
    next_keys[RegLayerTrig] = 16'h5000;
    next_keys[RegCancelA]   = 16'h0029;
    next_keys[RegCancelB]   = 16'hFFFF;
    apply_keys();
    ks  = key_reg[RegShiftTrig];
    kc  = key_reg[RegCtrlTrig];
    ka  = key_reg[RegAltTrig];
    kg  = key_reg[RegGuiTrig];
    kl  = key_reg[RegLayerTrig];
    kx1 = key_reg[RegCancelA];
    kx2 = key_reg[RegCancelB];
    // tap shift, then a plain key release consumes it
    queue_key(ks, 1'b1); queue_key(ks, 1'b0);
    queue_key(16'h0000, 1'b1); queue_key(16'h0000, 1'b0);
    // ctrl held while typing
    queue_key(kc, 1'b1); queue_key(16'h0004, 1'b1);
    queue_key(16'h0004, 1'b0); queue_key(kc, 1'b0);
    // queued modifiers dropped by either cancel key
    queue_key(kg, 1'b1); queue_key(kg, 1'b0); queue_key(kx1, 1'b1);
    queue_key(ka, 1'b1); queue_key(ka, 1'b0); queue_key(kx2, 1'b1);
    // layer held, mod tapped, plain release parks it, layer release clears it
    queue_key(kl, 1'b1); queue_key(ks, 1'b1); queue_key(ks, 1'b0);
    queue_key(16'h0004, 1'b0); queue_key(kl, 1'b0);
    // layer trigger pressed again while in down_used
    queue_key(kl, 1'b1); queue_key(ka, 1'b1); queue_key(ka, 1'b0);
    queue_key(kl, 1'b1); queue_key(kl, 1'b0);
    drain();

    for (p = 0; p < 6; p++) begin
      case (p)
        1: for (r = 0; r < NumKeyRegs; r++) next_keys[r] = 16'hFFFF;
        2: begin
          // shared codes: shift/ctrl, alt/layer, gui/cancel
          next_keys[RegShiftTrig] = KeyW'($urandom);
          next_keys[RegCtrlTrig]  = next_keys[RegShiftTrig];
          next_keys[RegAltTrig]   = KeyW'($urandom);
          next_keys[RegLayerTrig] = next_keys[RegAltTrig];
          next_keys[RegGuiTrig]   = KeyW'($urandom);
          next_keys[RegCancelA]   = next_keys[RegGuiTrig];
          next_keys[RegCancelB]   = KeyW'($urandom);
        end
        3: for (r = 0; r < NumKeyRegs; r++) next_keys[r] = KeyW'($urandom_range(0, 7));
        5: begin
          for (r = 0; r < NumMods; r++) next_keys[r] = 16'h0000;
          next_keys[RegLayerTrig] = 16'hFFFF;
          next_keys[RegCancelA]   = KeyW'($urandom);
          next_keys[RegCancelB]   = next_keys[RegCancelA];
        end
        default: for (r = 0; r < NumKeyRegs; r++) next_keys[r] = KeyW'($urandom);
      endcase
      apply_keys();
      run_random((p == 1 || p == 5) ? 120 : 250, p == 4);
    end

    $display("Checked %0d results from %0d key events over %0d keycode settings.",
             n_results, n_events, n_settings + 1);
    $display("Taps, holds, cancels, layer holds and shared keycodes ran with random stalls.");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
hdl/oml_pkg.sv
hdl/oml_key_match.sv
hdl/oml_mod_fsm.sv
hdl/oml_layer_fsm.sv
hdl/oneshot_modifier_layer_fsm_unit.sv
tb/sv/testbench.sv
